[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and rst_n in the scope where they are used.
`define LCR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle check");

`define LCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in next cycle check");

`endif

[rtl/lcr_pkg.sv]
`default_nettype none

package lcr_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int SLOPE_W     = 32;
  localparam int TIMEOUT_W   = 24;
  localparam int SUM_W       = 32;
  localparam int NCNT_W      = 8;
  localparam int PDP_W       = 5;
  localparam int EXTRA_W     = 2;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = SLOPE_W + SAMPLE_W + 1;
  localparam int WEIGHT_W    = PROD_W - FRAC_W;
  localparam int REQ_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = 2 + SAMPLE_W + WEIGHT_W + SAMPLE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 24'h800000;
  localparam logic [SLOPE_W-1:0]  SLOPE_RESET = 32'h0001_0000;

  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TARE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PDOWN = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PWRUP = 3'd4;

  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAMPLE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TARE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TSAMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PDP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FPU     = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HI,
    PH_LO,
    PH_PDHI,
    PH_PDLO,
    PH_OFF
  } phase_t;

  typedef enum logic [1:0] {
    JOB_FETCH,
    JOB_TARE,
    JOB_PWRUP
  } job_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DIV_GO,
    SQ_DIV_WAIT,
    SQ_MUL,
    SQ_OUT
  } seq_t;

  typedef struct packed {
    logic                wait_clr;
    logic                wait_inc;
    logic                tare_clr;
    logic                cnt_clr;
    logic                cnt_inc;
    logic                shift_clr;
    logic                shift_en;
    logic                sample_load;
    logic                tare_acc;
    logic                div_start;
    logic                prod_load;
    logic                out_load;
    logic                out_sck;
    logic                out_busy;
    logic [STATUS_W-1:0] out_status;
  } lcr_cmd_t;

  typedef struct packed {
    logic tmo_zero;
    logic wait_hit;
    logic wait_hit0;
    logic last_bit;
    logic tare_last;
    logic pd_done;
    logic pd_zero;
    logic fetch_pu;
    logic div_done;
  } lcr_stat_t;

endpackage

`default_nettype wire

[rtl/load_cell_adc_serial_reader.sv]
// An accepted transaction runs the multiply state (product registered), then
// output state, which loads out_tdata and out_tvalid once any pending result is
// taken; in_tready low meanwhile. Ending a tare adds a bit-serial sum divide.
// Reset (rst_n low, synchronous) returns the block to idle and powered up,
// clears the sample, offset and tare state and loads the register defaults.
`default_nettype none

module load_cell_adc_serial_reader #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // dout_level in bit 0, zero padding above.
  input  wire logic [lcr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type.
  input  wire logic [lcr_pkg::REQ_W-1:0]        in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // sck_level, busy_res, raw_sample, weight, offset_value, zero padding.
  output logic [lcr_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // status.
  output logic [lcr_pkg::STATUS_W-1:0]          out_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [lcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lcr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lcr_pkg::*;

  lcr_cmd_t  cmd;
  lcr_stat_t stat;
  logic                       out_sck;
  logic                       out_busy;
  logic [STATUS_W-1:0]        out_status;
  logic [SAMPLE_W-1:0]        out_raw;
  logic signed [WEIGHT_W-1:0] out_weight;
  logic [SAMPLE_W-1:0]        out_offset;

  lcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req_type  (in_tuser),
    .dout      (in_tdata[0]),
    .stat      (stat),
    .cmd       (cmd),
    .out_ready (out_tready),
    .out_valid (out_tvalid)
  );

  lcr_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .dout       (in_tdata[0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_sck    (out_sck),
    .out_busy   (out_busy),
    .out_status (out_status),
    .out_raw    (out_raw),
    .out_weight (out_weight),
    .out_offset (out_offset)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_offset, out_weight, out_raw, out_busy, out_sck};
  assign out_tuser = out_status;

endmodule

`default_nettype wire

[rtl/lcr_div.sv]
`default_nettype none

module lcr_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [lcr_pkg::SUM_W-1:0]  dividend,
  input  wire logic [lcr_pkg::NCNT_W-1:0] divisor,
  output logic                          done,
  output logic [lcr_pkg::SUM_W-1:0]       quotient
);
  import lcr_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [NCNT_W-1:0] rem_r;
  logic [NCNT_W-1:0] den_r;
  logic [SUM_W-1:0]  quo_r;
  logic [NCNT_W:0]   trial;
  logic              fits;
  logic [NCNT_W-1:0] rem_nxt;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? NCNT_W'(trial - {1'b0, den_r}) : trial[NCNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/lcr_dp.sv]
`default_nettype none

module lcr_dp #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [lcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                         dout,
  input  wire lcr_pkg::lcr_cmd_t              cmd,
  output lcr_pkg::lcr_stat_t                  stat,
  output logic                              out_sck,
  output logic                              out_busy,
  output logic [lcr_pkg::STATUS_W-1:0]        out_status,
  output logic [lcr_pkg::SAMPLE_W-1:0]        out_raw,
  output logic signed [lcr_pkg::WEIGHT_W-1:0] out_weight,
  output logic [lcr_pkg::SAMPLE_W-1:0]        out_offset
);
  import lcr_pkg::*;

  localparam int CNT_RAW_W = $clog2(SAMPLE_BITS + 5);
  localparam int CNT_W     = (CNT_RAW_W > PDP_W) ? CNT_RAW_W : PDP_W;

  logic [EXTRA_W-1:0]      extra_r;
  logic [TIMEOUT_W-1:0]    timeout_r;
  logic signed [SLOPE_W-1:0] slope_r;
  logic [NCNT_W-1:0]       tsamp_r;
  logic [PDP_W-1:0]        pdp_r;
  logic                    fpu_r;

  logic [TIMEOUT_W-1:0]    wait_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [SAMPLE_W-1:0]     shift_r;
  logic [SAMPLE_W-1:0]     last_r;
  logic [SAMPLE_W-1:0]     off_r;
  logic [SUM_W-1:0]        sum_r;
  logic [NCNT_W-1:0]       tdone_r;
  logic signed [PROD_W-1:0] prod_r;

  logic [TIMEOUT_W-1:0]    wait_base;
  logic [TIMEOUT_W-1:0]    wait_inc_val;
  logic [SAMPLE_W-1:0]     shift_nxt;
  logic [SAMPLE_W-1:0]     sample_nxt;
  logic [NCNT_W-1:0]       tdone_inc;
  logic [NCNT_W-1:0]       n_eff;
  logic signed [SAMPLE_W:0] diff;
  logic                    div_done;
  logic [SUM_W-1:0]        div_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extra_r   <= '0;
      timeout_r <= '0;
      slope_r   <= SLOPE_RESET;
      tsamp_r   <= NCNT_W'(1);
      pdp_r     <= '0;
      fpu_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXTRA:   extra_r   <= cfg_wdata[EXTRA_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_SLOPE:   slope_r   <= cfg_wdata[SLOPE_W-1:0];
        CFG_TSAMP:   tsamp_r   <= cfg_wdata[NCNT_W-1:0];
        CFG_PDP:     pdp_r     <= cfg_wdata[PDP_W-1:0];
        CFG_FPU:     fpu_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    wait_base    = cmd.wait_clr ? '0 : wait_r;
    wait_inc_val = wait_base + TIMEOUT_W'(1);
    shift_nxt    = (cnt_r < CNT_W'(SAMPLE_BITS)) ? {shift_r[SAMPLE_W-2:0], dout} : shift_r;
    sample_nxt   = shift_nxt ^ SIGN_FLIP;
    tdone_inc    = tdone_r + NCNT_W'(1);
    n_eff        = (tsamp_r == '0) ? NCNT_W'(1) : tsamp_r;
    diff         = $signed({1'b0, last_r}) - $signed({1'b0, off_r});
  end

  always_comb begin
    stat.tmo_zero  = (timeout_r == '0);
    stat.wait_hit  = ((wait_r + TIMEOUT_W'(1)) >= timeout_r);
    stat.wait_hit0 = (timeout_r <= TIMEOUT_W'(1));
    stat.last_bit  = (cnt_r >= (CNT_W'(SAMPLE_BITS) + CNT_W'(extra_r)));
    stat.tare_last = (tdone_inc >= n_eff);
    stat.pd_done   = (cnt_r >= CNT_W'(pdp_r));
    stat.pd_zero   = (pdp_r == '0);
    stat.fetch_pu  = fpu_r;
    stat.div_done  = div_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r  <= '0;
      cnt_r   <= '0;
      shift_r <= '0;
      last_r  <= '0;
      off_r   <= '0;
      sum_r   <= '0;
      tdone_r <= '0;
    end else begin
      if (cmd.wait_inc) begin
        wait_r <= wait_inc_val;
      end else if (cmd.wait_clr) begin
        wait_r <= '0;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.shift_clr) begin
        shift_r <= '0;
      end else if (cmd.shift_en) begin
        shift_r <= shift_nxt;
      end
      if (cmd.sample_load) begin
        last_r <= sample_nxt;
      end
      if (cmd.tare_clr) begin
        sum_r   <= '0;
        tdone_r <= '0;
      end else if (cmd.tare_acc) begin
        sum_r   <= sum_r + SUM_W'(sample_nxt);
        tdone_r <= tdone_inc;
      end
      if (div_done) begin
        off_r <= div_q[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_load) begin
      prod_r <= slope_r * diff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sck    <= cmd.out_sck;
      out_busy   <= cmd.out_busy;
      out_status <= cmd.out_status;
      out_raw    <= last_r;
      out_weight <= prod_r[PROD_W-1:FRAC_W];
      out_offset <= off_r;
    end
  end

  lcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

`default_nettype wire

[rtl/lcr_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"

module lcr_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [lcr_pkg::REQ_W-1:0] req_type,
  input  wire logic                    dout,
  input  wire lcr_pkg::lcr_stat_t        stat,
  output lcr_pkg::lcr_cmd_t              cmd,
  input  wire logic                    out_ready,
  output logic                         out_valid
);
  import lcr_pkg::*;

  phase_t phase_r, phase_nxt, ph;
  job_t   job_r, job_nxt;
  seq_t   seq_r, seq_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_sck_r, res_busy_r;
  logic [STATUS_W-1:0] res_status_r;

  logic acc;
  logic handled, wait_fresh, cnt_fresh, need_div, out_load;
  logic t_sck, t_busy;
  logic [STATUS_W-1:0] t_status;
  logic t_wait_clr, t_wait_inc, t_tare_clr, t_cnt_clr, t_cnt_inc;
  logic t_shift_clr, t_shift_en, t_sample_load, t_tare_acc;

  assign in_ready  = (seq_r == SQ_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      job_r       <= JOB_FETCH;
      seq_r       <= SQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      job_r       <= job_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_sck_r    <= t_sck;
      res_busy_r   <= t_busy;
      res_status_r <= t_status;
    end
  end

  always_comb begin
    ph            = phase_r;
    job_nxt       = job_r;
    handled       = 1'b0;
    wait_fresh    = 1'b0;
    cnt_fresh     = 1'b0;
    need_div      = 1'b0;
    t_sck         = 1'b0;
    t_busy        = 1'b0;
    t_status      = ST_NONE;
    t_wait_clr    = 1'b0;
    t_wait_inc    = 1'b0;
    t_tare_clr    = 1'b0;
    t_cnt_clr     = 1'b0;
    t_cnt_inc     = 1'b0;
    t_shift_clr   = 1'b0;
    t_shift_en    = 1'b0;
    t_sample_load = 1'b0;
    t_tare_acc    = 1'b0;

    // Requests are taken only from idle, or power up from the powered-down state.
    if (phase_r == PH_IDLE) begin
      if (req_type == REQ_FETCH || req_type == REQ_TARE) begin
        job_nxt    = (req_type == REQ_FETCH) ? JOB_FETCH : JOB_TARE;
        t_tare_clr = (req_type == REQ_TARE);
        ph         = PH_WAIT;
        wait_fresh = 1'b1;
        t_wait_clr = 1'b1;
      end else if (req_type == REQ_PDOWN) begin
        ph        = PH_PDHI;
        cnt_fresh = 1'b1;
        t_cnt_clr = 1'b1;
      end
    end else if (phase_r == PH_OFF && req_type == REQ_PWRUP) begin
      handled = 1'b1;
      if (stat.fetch_pu) begin
        job_nxt    = JOB_PWRUP;
        ph         = PH_WAIT;
        t_wait_clr = 1'b1;
        t_busy     = 1'b1;
      end else begin
        ph = PH_IDLE;
      end
    end

    phase_nxt = ph;

    if (!handled) begin
      case (ph)
        PH_WAIT: begin
          if (stat.tmo_zero || !dout) begin
            phase_nxt   = PH_LO;
            t_cnt_clr   = 1'b1;
            t_shift_clr = 1'b1;
            t_sck       = 1'b1;
            t_busy      = 1'b1;
          end else begin
            t_wait_inc = 1'b1;
            if (wait_fresh ? stat.wait_hit0 : stat.wait_hit) begin
              t_status  = ST_TIMEOUT;
              phase_nxt = PH_IDLE;
            end else begin
              t_busy = 1'b1;
            end
          end
        end
        PH_HI: begin
          t_sck     = 1'b1;
          t_busy    = 1'b1;
          phase_nxt = PH_LO;
        end
        PH_LO: begin
          t_shift_en = 1'b1;
          t_cnt_inc  = 1'b1;
          if (stat.last_bit) begin
            t_sample_load = 1'b1;
            if (job_r == JOB_TARE) begin
              t_tare_acc = 1'b1;
              if (stat.tare_last) begin
                t_status  = ST_TARE;
                phase_nxt = PH_IDLE;
                need_div  = 1'b1;
              end else begin
                phase_nxt  = PH_WAIT;
                t_wait_clr = 1'b1;
                t_busy     = 1'b1;
              end
            end else begin
              t_status  = (job_r == JOB_FETCH) ? ST_SAMPLE : ST_NONE;
              phase_nxt = PH_IDLE;
            end
          end else begin
            phase_nxt = PH_HI;
            t_busy    = 1'b1;
          end
        end
        PH_PDHI: begin
          t_sck = 1'b1;
          if (cnt_fresh ? stat.pd_zero : stat.pd_done) begin
            phase_nxt = PH_OFF;
          end else begin
            phase_nxt = PH_PDLO;
            t_busy    = 1'b1;
          end
        end
        PH_PDLO: begin
          t_busy    = 1'b1;
          t_cnt_inc = 1'b1;
          phase_nxt = PH_PDHI;
        end
        PH_OFF: begin
          t_sck = 1'b1;
        end
        default: begin
          t_sck = 1'b0;
        end
      endcase
    end

    if (!acc) begin
      phase_nxt = phase_r;
      job_nxt   = job_r;
    end

    seq_nxt  = seq_r;
    out_load = 1'b0;
    case (seq_r)
      SQ_IDLE: begin
        if (acc) begin
          seq_nxt = need_div ? SQ_DIV_GO : SQ_MUL;
        end
      end
      SQ_DIV_GO: begin
        seq_nxt = SQ_DIV_WAIT;
      end
      SQ_DIV_WAIT: begin
        if (stat.div_done) begin
          seq_nxt = SQ_MUL;
        end
      end
      SQ_MUL: begin
        seq_nxt = SQ_OUT;
      end
      SQ_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          seq_nxt  = SQ_IDLE;
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    cmd.wait_clr    = acc && t_wait_clr;
    cmd.wait_inc    = acc && t_wait_inc;
    cmd.tare_clr    = acc && t_tare_clr;
    cmd.cnt_clr     = acc && t_cnt_clr;
    cmd.cnt_inc     = acc && t_cnt_inc;
    cmd.shift_clr   = acc && t_shift_clr;
    cmd.shift_en    = acc && t_shift_en;
    cmd.sample_load = acc && t_sample_load;
    cmd.tare_acc    = acc && t_tare_acc;
    cmd.div_start   = (seq_r == SQ_DIV_GO);
    cmd.prod_load   = (seq_r == SQ_MUL);
    cmd.out_load    = out_load;
    cmd.out_sck     = res_sck_r;
    cmd.out_busy    = res_busy_r;
    cmd.out_status  = res_status_r;
  end

  `LCR_ASSERT_NEXT(a_one_in_flight, acc, !in_ready)
  `LCR_ASSERT_NEXT(a_quiet_tick_rests, acc && !t_busy, phase_r == PH_IDLE || phase_r == PH_OFF)
  `LCR_ASSERT_SAME(a_tare_status_job, acc && t_status == ST_TARE, job_r == JOB_TARE)
  `LCR_ASSERT_NEXT(a_div_follows_tare, acc && need_div, seq_r == SQ_DIV_GO)

endmodule

`default_nettype wire
